@@ design/failsafe_arming_supervisor_assert.svh @@
// Assertion macros for the failsafe and arming supervisor.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FAILSAFE_ARMING_SUPERVISOR_ASSERT_SVH
`define FAILSAFE_ARMING_SUPERVISOR_ASSERT_SVH

// The condition must hold at every clock edge.
`define FAS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/fas_pkg.sv @@
// Shared types and constants for the failsafe and arming supervisor.
// No dependencies; used by fas_core and failsafe_arming_supervisor.
`default_nettype none

package fas_pkg;

	localparam int TIME_W   = 32;
	localparam int PHASE_W  = 3;
	localparam int DIS_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HOLD     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_STAGE1   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STAGE2   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RECOVERY = 3'd4;

	localparam int DIS_ARM_BIT = 0;
	localparam int DIS_THR_BIT = 1;
	localparam int DIS_FS_BIT  = 2;
	localparam int DIS_USB_BIT = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE1_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RTH_ON_FS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PREARM_CYCLE  = 3'd4;

	localparam logic [TIME_W-1:0] HOLD_TIME_RST     = 32'd100000;
	localparam logic [TIME_W-1:0] STAGE1_TIME_RST   = 32'd1000000;
	localparam logic [TIME_W-1:0] RECOVERY_TIME_RST = 32'd1000000;

	typedef struct packed {
		logic [TIME_W-1:0] hold_time_us;
		logic [TIME_W-1:0] stage1_time_us;
		logic [TIME_W-1:0] recovery_time_us;
		logic              home_on_loss;
		logic              prearm_needs_cycle;
	} fas_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [TIME_W-1:0]  phase_start;
		logic               arm_flag;
		logic               fs_flag;
		logic               blocked_flag;
		logic               override_flag;
		logic               rearm_hold_ok;
		logic               checked_arm;
		logic               ready_seen;
		logic [1:0]         disable_latch;
		logic               prev_fs_active;
		logic               prearm_ok;
	} fas_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_us;
		logic [TIME_W-1:0] last_frame_us;
		logic              link_up;
		logic              signal_lost;
		logic              home_nav;
		logic              arm_switch;
		logic              prearm_switch;
		logic              usb_attached;
		logic              throttle_safe;
		logic              turtle_request;
		logic              turtle_ok;
	} fas_in_t;

	typedef struct packed {
		logic               armed;
		logic               failsafe_on;
		logic               outputs_blocked;
		logic [PHASE_W-1:0] phase_out;
		logic               stick_override;
		logic               rth_failsafe;
		logic [DIS_W-1:0]   disable_reasons;
		logic               motor_forward_req;
	} fas_res_t;

endpackage

`default_nettype wire

@@ design/failsafe_arming_supervisor.sv @@
// Failsafe and arming supervisor: one control-loop tick per input item.
// Depends on fas_pkg, fas_core and failsafe_arming_supervisor_assert.svh.
//
// Usage:
//   s_axis carries one tick of receiver and switch inputs per item; m_axis
//   returns exactly one result item per tick, in order.
//   cfg_valid/cfg_ready write one register by index (0 hold time, 1 stage-1
//   time, 2 recovery time, 3 return home on failsafe, 4 prearm cycle rule);
//   other indexes are ignored. cfg_ready is always high. Write only when idle.
//   A tick is held in the input stage, then its result in the result register,
//   which drives m_axis (two register stages). Throughput: one tick per cycle
//   while the receiver does not stall, set by the combinational state update
//   in fas_core between the input stage and the result register.
//   When the receiver stalls, the result register holds and the input stage
//   takes one more tick, after which s_axis_tready drops until the result
//   is taken.
//   Reset clears both stages, loads the register defaults and puts the
//   supervisor in the idle phase with failsafe and output block set and
//   the arm switch disable reason latched.
`default_nettype none

module failsafe_arming_supervisor (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// now_us[31:0], last_frame_us[63:32], link_up[64], signal_lost[65],
	// home_nav[66], arm_switch[67], prearm_switch[68], usb_attached[69],
	// throttle_safe[70], turtle_request[71], turtle_ok[72], zeros above.
	input  wire  [fas_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// armed[0], failsafe_on[1], outputs_blocked[2], phase_out[5:3],
	// stick_override[6], rth_failsafe[7], disable_reasons[11:8],
	// motor_forward_req[12], zeros above.
	output logic [fas_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [fas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [fas_pkg::TIME_W-1:0]      cfg_data
);
	import fas_pkg::*;

	fas_cfg_t   cfg_q;
	fas_state_t st_q;
	fas_state_t st_nxt;
	fas_in_t    in_s1;
	fas_res_t   res;
	fas_res_t   res_s2;
	logic       vld_s1;
	logic       vld_s2;
	logic       adv;

	assign cfg_ready     = 1'b1;
	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W - $bits(fas_res_t)){1'b0}},
		res_s2.motor_forward_req, res_s2.disable_reasons, res_s2.rth_failsafe,
		res_s2.stick_override, res_s2.phase_out, res_s2.outputs_blocked,
		res_s2.failsafe_on, res_s2.armed};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_us       <= HOLD_TIME_RST;
			cfg_q.stage1_time_us     <= STAGE1_TIME_RST;
			cfg_q.recovery_time_us   <= RECOVERY_TIME_RST;
			cfg_q.home_on_loss       <= 1'b0;
			cfg_q.prearm_needs_cycle <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HOLD_TIME:     cfg_q.hold_time_us       <= cfg_data;
				CFG_STAGE1_TIME:   cfg_q.stage1_time_us     <= cfg_data;
				CFG_RECOVERY_TIME: cfg_q.recovery_time_us   <= cfg_data;
				CFG_RTH_ON_FS:     cfg_q.home_on_loss       <= cfg_data[0];
				CFG_PREARM_CYCLE:  cfg_q.prearm_needs_cycle <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase          <= PH_IDLE;
			st_q.phase_start    <= '0;
			st_q.arm_flag       <= 1'b0;
			st_q.fs_flag        <= 1'b1;
			st_q.blocked_flag   <= 1'b1;
			st_q.override_flag  <= 1'b0;
			st_q.rearm_hold_ok  <= 1'b0;
			st_q.checked_arm    <= 1'b0;
			st_q.ready_seen     <= 1'b0;
			st_q.disable_latch  <= 2'b01;
			st_q.prev_fs_active <= 1'b0;
			st_q.prearm_ok      <= 1'b1;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_s1.now_us         <= s_axis_tdata[31:0];
			in_s1.last_frame_us  <= s_axis_tdata[63:32];
			in_s1.link_up        <= s_axis_tdata[64];
			in_s1.signal_lost    <= s_axis_tdata[65];
			in_s1.home_nav       <= s_axis_tdata[66];
			in_s1.arm_switch     <= s_axis_tdata[67];
			in_s1.prearm_switch  <= s_axis_tdata[68];
			in_s1.usb_attached   <= s_axis_tdata[69];
			in_s1.throttle_safe  <= s_axis_tdata[70];
			in_s1.turtle_request <= s_axis_tdata[71];
			in_s1.turtle_ok      <= s_axis_tdata[72];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	fas_core u_core (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (in_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

`include "failsafe_arming_supervisor_assert.svh"

	`FAS_ASSERT_ALWAYS(a_armed_no_reason,
		!(m_axis_tvalid && res_s2.armed && res_s2.disable_reasons != '0),
		"armed result carries a disable reason")
	`FAS_ASSERT_ALWAYS(a_ready_only_when_full,
		s_axis_tready || (vld_s1 && vld_s2 && !m_axis_tready),
		"input stalled while the pipeline can move")
	`FAS_ASSERT_NEXT(a_state_holds, !adv, $stable(st_q),
		"supervisor state changed without a tick")

endmodule

`default_nettype wire

@@ design/fas_core.sv @@
// Combinational tick update: failsafe phase machine first, then arming logic.
// Depends on fas_pkg for the state, input, configuration and result types.
`default_nettype none

module fas_core (
	input  wire fas_pkg::fas_cfg_t   cfg,
	input  wire fas_pkg::fas_state_t st,
	input  wire fas_pkg::fas_in_t    item,
	output fas_pkg::fas_state_t      st_nxt,
	output fas_pkg::fas_res_t        res
);
	import fas_pkg::*;

	logic [TIME_W-1:0] loss;
	logic [TIME_W-1:0] loss_past_hold;
	logic [TIME_W-1:0] recovery_elapsed;
	logic              rth_fs;

	assign loss             = item.now_us - item.last_frame_us;
	assign loss_past_hold   = loss - cfg.hold_time_us;
	assign recovery_elapsed = item.now_us - st.phase_start;
	assign rth_fs           = item.home_nav && cfg.home_on_loss && item.signal_lost;

	always_comb begin
		fas_state_t      n;
		logic            fa;
		logic            fda;
		logic            can;
		logic            mfwd;
		logic [DIS_W-1:0] dis;
		logic [PHASE_W-1:0] tgt;
		logic            do_drop;
		logic            guard_rel;

		n         = st;
		mfwd      = 1'b0;
		dis       = '0;
		tgt       = st.phase;
		do_drop   = 1'b0;
		guard_rel = 1'b0;

		// Failsafe update.
		if (!item.link_up) begin
			n.fs_flag      = 1'b1;
			n.blocked_flag = 1'b1;
			guard_rel      = 1'b1;
			tgt            = PH_IDLE;
		end else if (item.signal_lost) begin
			if (rth_fs) begin
				n.fs_flag      = 1'b1;
				n.blocked_flag = 1'b0;
				tgt            = PH_STAGE1;
			end else if (st.phase == PH_STAGE2 || st.phase == PH_RECOVERY) begin
				do_drop = 1'b1;
			end else if (loss < cfg.hold_time_us) begin
				n.fs_flag      = 1'b0;
				n.blocked_flag = 1'b0;
				tgt            = PH_HOLD;
			end else if (loss_past_hold < cfg.stage1_time_us) begin
				n.fs_flag       = 1'b1;
				n.blocked_flag  = 1'b0;
				n.override_flag = 1'b1;
				tgt             = PH_STAGE1;
			end else begin
				guard_rel = 1'b1;
				do_drop   = 1'b1;
			end
		end else if (st.phase == PH_STAGE2) begin
			n.fs_flag      = 1'b1;
			n.blocked_flag = 1'b1;
			tgt            = PH_RECOVERY;
		end else if (st.phase == PH_RECOVERY) begin
			n.fs_flag      = 1'b1;
			n.blocked_flag = 1'b1;
			if (recovery_elapsed >= cfg.recovery_time_us) begin
				n.fs_flag      = 1'b0;
				n.blocked_flag = 1'b0;
				tgt            = PH_IDLE;
			end
		end else begin
			n.fs_flag      = 1'b0;
			n.blocked_flag = 1'b0;
			guard_rel      = 1'b1;
			tgt            = PH_IDLE;
		end

		if (guard_rel && st.phase == PH_STAGE1 && !item.home_nav) begin
			n.override_flag = 1'b0;
		end
		if (do_drop) begin
			n.fs_flag      = 1'b1;
			n.blocked_flag = 1'b1;
			tgt            = PH_STAGE2;
			if (st.arm_flag) begin
				n.rearm_hold_ok = 1'b1;
			end
			n.arm_flag = 1'b0;
		end
		if (st.phase != tgt) begin
			n.phase       = tgt;
			n.phase_start = item.now_us;
		end

		// Arming update.
		fa  = n.fs_flag || item.signal_lost;
		fda = fa && (!n.arm_flag || n.blocked_flag);

		if (!cfg.prearm_needs_cycle || !item.prearm_switch) begin
			n.prearm_ok = 1'b1;
		end
		if (!item.prearm_switch) begin
			n.rearm_hold_ok = 1'b0;
		end
		if (st.prev_fs_active && !fa && !item.arm_switch) begin
			n.disable_latch[DIS_ARM_BIT] = 1'b0;
		end
		n.prev_fs_active = fa;
		if (!item.link_up) begin
			n.ready_seen = 1'b0;
		end
		dis[DIS_FS_BIT]  = fda;
		dis[DIS_USB_BIT] = item.usb_attached;
		if (item.arm_switch && ((fa && !n.arm_flag) || item.usb_attached)) begin
			n.disable_latch[DIS_ARM_BIT] = 1'b1;
		end

		can = !fa && !n.checked_arm && (n.disable_latch == 2'b00) && item.prearm_switch &&
			(!cfg.prearm_needs_cycle || n.prearm_ok || n.rearm_hold_ok) && item.throttle_safe;

		if (item.arm_switch && !item.usb_attached && (n.arm_flag || !fa)) begin
			if (can) begin
				n.arm_flag = 1'b1;
				if (cfg.prearm_needs_cycle) begin
					n.prearm_ok = 1'b0;
				end
				n.rearm_hold_ok = 1'b0;
				mfwd            = !item.turtle_ok;
			end else if (!n.arm_flag) begin
				if (item.throttle_safe) begin
					n.disable_latch[DIS_ARM_BIT] = 1'b1;
				end else begin
					n.disable_latch[DIS_THR_BIT] = 1'b1;
				end
			end
			n.checked_arm = 1'b1;
		end else begin
			n.arm_flag    = 1'b0;
			n.checked_arm = 1'b0;
			if (item.link_up && !item.arm_switch) begin
				if (n.ready_seen) begin
					n.disable_latch[DIS_ARM_BIT] = 1'b0;
				end
				n.ready_seen = 1'b1;
			end
			n.disable_latch[DIS_THR_BIT] = 1'b0;
		end

		if (item.turtle_request && !item.turtle_ok) begin
			n.disable_latch[DIS_ARM_BIT] = 1'b1;
		end
		dis[1:0] = n.disable_latch;
		if (dis != '0) begin
			n.arm_flag = 1'b0;
		end

		st_nxt                = n;
		res.armed             = n.arm_flag;
		res.failsafe_on       = n.fs_flag;
		res.outputs_blocked   = n.blocked_flag;
		res.phase_out         = n.phase;
		res.stick_override    = n.override_flag;
		res.rth_failsafe      = rth_fs;
		res.disable_reasons   = dis;
		res.motor_forward_req = mfwd;
	end

endmodule

`default_nettype wire
